FILE: rtl/core/npa_pkg.sv
package npa_pkg;

   // item kinds on the request channel
   localparam logic [1:0] KIND_LOAD_NODE    = 2'd0;
   localparam logic [1:0] KIND_LOAD_LATENCY = 2'd1;
   localparam logic [1:0] KIND_ALLOCATE     = 2'd2;

   // request item
   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  node_index;
      logic [13:0] node_resource;
      logic [13:0] node_bandwidth;
      logic        node_busy;
      logic [15:0] node_latency;
      logic [13:0] job_resource;
      logic [13:0] job_bandwidth;
      logic [15:0] job_latency;
   } npa_req_type;

   // result item
   typedef struct packed {
      logic               found;
      logic signed [31:0] score;
      logic [5:0]         first_node;
      logic [5:0]         second_node;
      logic               single_node;
   } npa_rsp_type;

   // one node entry: resource and bandwidth capacity
   typedef struct packed {
      logic [13:0] res;
      logic [13:0] bw;
   } npa_entry_type;

endpackage

FILE: rtl/core/node_pair_allocator.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  npa_req_type: load node, load latency, job
// rsp_      out        rsp_valid / rsp_ready  npa_rsp_type: one per job item
// csr_      in         csr_valid / csr_ready  latency_offset (16 bit), always ready
//
// Load items are written on accept and leave the sequencer idle. A job item walks all
// NODES*(NODES+1)/2 node pairs, one pair per cycle through a single scoring pipeline
// (memory read, sums, two squaring stages, score, best-so-far compare), then drains
// it and commits the result. req_ready is high only while the sequencer is idle.
// Synchronous active-high reset clears busy flags, the offset and all control state;
// node tables are undefined until loaded. A waiting result does not block load
// items; a following job finishes its scan and holds until the result is taken.
module node_pair_allocator
   import npa_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  npa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output npa_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [AW-1:0] LAST = AW'(NODES - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } npa_state_type;

   npa_state_type state_ff, state_in;

   logic [15:0]       offset_ff;
   logic [NODES-1:0]  busy_ff;
   logic [AW-1:0]     i_ff, i_in, j_ff, j_in;
   logic signed [16:0] limit_ff;
   logic [13:0]       job_r_ff, job_b_ff;

   logic              rsp_valid_ff;
   npa_rsp_type       rsp_ff;

   // best pair so far
   logic              have_ff;
   logic [32:0]       best_ff;
   logic [AW-1:0]     bi_ff, bj_ff;

   // handshakes
   logic req_fire, load_node, load_lat, job_start, rsp_free, commit, in_range;
   logic [AW-1:0] wr_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = 32'(req_data.node_index) < NODES;
   assign wr_addr   = AW'(req_data.node_index);
   assign load_node = req_fire && in_range && (req_data.kind == KIND_LOAD_NODE);
   assign load_lat  = req_fire && in_range && (req_data.kind == KIND_LOAD_LATENCY);
   assign job_start = req_fire && (req_data.kind == KIND_ALLOCATE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_DONE) && rsp_free;

   // pipeline valid bits and tags
   logic          s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic [AW-1:0] s1_i_ff, s1_j_ff, s2_i_ff, s2_j_ff, s3_i_ff, s3_j_ff;
   logic [AW-1:0] s4_i_ff, s4_j_ff, s5_i_ff, s5_j_ff;
   logic          pipe_busy;

   assign pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff || s5_vld_ff;

   // sequencer: next state and pair counters
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            if (job_start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (j_ff == LAST) begin
               if (i_ff == LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         offset_ff <= csr_data;
      end
   end

   // job parameters, latched at accept
   always_ff @(posedge clock) begin
      if (job_start) begin
         limit_ff <= $signed({1'b0, req_data.job_latency}) - $signed({1'b0, offset_ff});
         job_r_ff <= req_data.job_resource;
         job_b_ff <= req_data.job_bandwidth;
      end
   end

   // busy flags: written by node loads, set by a committed allocation
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         if (load_node) busy_ff[wr_addr] <= req_data.node_busy;
         if (commit && have_ff) begin
            busy_ff[bi_ff] <= 1'b1;
            busy_ff[bj_ff] <= 1'b1;
         end
      end
   end

   // node tables: one write port each, read at pair indices i and j
   npa_entry_type entry_mem [NODES];
   logic [15:0]   lat_mem   [NODES];
   npa_entry_type rb_i_ff, rb_j_ff;
   logic [15:0]   lat_i_ff, lat_j_ff;

   always_ff @(posedge clock) begin
      if (load_node) entry_mem[wr_addr] <= '{res: req_data.node_resource,
                                             bw:  req_data.node_bandwidth};
      rb_i_ff <= entry_mem[i_ff];
      rb_j_ff <= entry_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (load_lat) lat_mem[wr_addr] <= req_data.node_latency;
      lat_i_ff <= lat_mem[i_ff];
      lat_j_ff <= lat_mem[j_ff];
   end

   // stage 1 side data: busy of either node
   logic s1_busy_ff;
   always_ff @(posedge clock) begin
      s1_busy_ff <= busy_ff[i_ff] || busy_ff[j_ff];
      s1_i_ff    <= i_ff;
      s1_j_ff    <= j_ff;
   end

   // stage 2: pair sums, slack and demand margins, rejection
   logic              same;
   logic [14:0]       rs_sum, bs_sum;
   logic [16:0]       ls_sum;
   logic [18:0]       slack_in;
   logic [15:0]       dr_in, db_in;
   logic              ok_in;

   assign same     = (s1_i_ff == s1_j_ff);
   assign rs_sum   = {1'b0, rb_i_ff.res} + (same ? 15'd0 : {1'b0, rb_j_ff.res});
   assign bs_sum   = {1'b0, rb_i_ff.bw} + (same ? 15'd0 : {1'b0, rb_j_ff.bw});
   assign ls_sum   = {1'b0, lat_i_ff} + (same ? 17'd0 : {1'b0, lat_j_ff});
   assign slack_in = {{2{limit_ff[16]}}, limit_ff} - {2'b00, ls_sum};
   assign dr_in    = {1'b0, rs_sum} - {2'b00, job_r_ff};
   assign db_in    = {1'b0, bs_sum} - {2'b00, job_b_ff};
   assign ok_in    = !s1_busy_ff && !slack_in[18] && !dr_in[15] && !db_in[15];

   logic        s2_ok_ff, s3_ok_ff, s4_ok_ff, s5_ok_ff;
   logic [14:0] s2_dr_ff, s2_db_ff, s3_db_ff;
   logic [18:0] s2_slack_ff, s3_slack_ff, s4_slack_ff;
   logic [29:0] s3_sq_r_ff, s4_sq_r_ff, s4_sq_b_ff;
   logic [32:0] s5_score_ff;

   // stages 2..5 datapath: margins, dr squared, db squared, score
   always_ff @(posedge clock) begin
      s2_ok_ff    <= ok_in;
      s2_dr_ff    <= dr_in[14:0];
      s2_db_ff    <= db_in[14:0];
      s2_slack_ff <= slack_in;
      s2_i_ff     <= s1_i_ff;
      s2_j_ff     <= s1_j_ff;

      s3_sq_r_ff  <= s2_dr_ff * s2_dr_ff;
      s3_db_ff    <= s2_db_ff;
      s3_slack_ff <= s2_slack_ff;
      s3_ok_ff    <= s2_ok_ff;
      s3_i_ff     <= s2_i_ff;
      s3_j_ff     <= s2_j_ff;

      s4_sq_b_ff  <= s3_db_ff * s3_db_ff;
      s4_sq_r_ff  <= s3_sq_r_ff;
      s4_slack_ff <= s3_slack_ff;
      s4_ok_ff    <= s3_ok_ff;
      s4_i_ff     <= s3_i_ff;
      s4_j_ff     <= s3_j_ff;

      s5_score_ff <= {3'b000, s4_sq_r_ff} + {3'b000, s4_sq_b_ff}
                     - {{14{s4_slack_ff[18]}}, s4_slack_ff};
      s5_ok_ff    <= s4_ok_ff;
      s5_i_ff     <= s4_i_ff;
      s5_j_ff     <= s4_j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == ST_SCAN);
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // stage 6: keep the lowest score, first pair in scan order wins ties
   logic better;
   assign better = s5_vld_ff && s5_ok_ff &&
                   (!have_ff || ($signed(s5_score_ff) < $signed(best_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (job_start) begin
         have_ff <= 1'b0;
      end else if (better) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_ff <= s5_score_ff;
         bi_ff   <= s5_i_ff;
         bj_ff   <= s5_j_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         if (have_ff) begin
            rsp_ff.found       <= 1'b1;
            rsp_ff.score       <= $signed(best_ff[31:0]);
            rsp_ff.first_node  <= 6'(bi_ff);
            rsp_ff.second_node <= 6'(bj_ff);
            rsp_ff.single_node <= (bi_ff == bj_ff);
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_job_starts_scan: assert property (@(posedge clock) disable iff (reset)
      job_start |=> (state_ff == ST_SCAN))
      else $error("job accept did not start the pair scan");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff >= i_ff))
      else $error("pair counter left the upper triangle");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.score == 0 &&
         rsp_data.first_node == 6'd0 && rsp_data.second_node == 6'd0 &&
         !rsp_data.single_node))
      else $error("not-found result carries nonzero fields");

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      commit |-> !pipe_busy)
      else $error("result committed before the scoring pipeline drained");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import npa_pkg::*;

   localparam int NODE_COUNT = 64;
   localparam int HOLD_CYCLES = 6000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES = 2200;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   npa_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   npa_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // items waiting to be offered, grants waiting to come back
   npa_req_type request_backlog[$];
   npa_rsp_type expected_grants[$];
   logic [15:0] offset_writes[$];

   // shadow copy of the node table and offset register
   logic [13:0] node_res [NODE_COUNT];
   logic [13:0] node_bw [NODE_COUNT];
   logic [15:0] node_lat [NODE_COUNT];
   bit          node_taken [NODE_COUNT];
   logic [15:0] offset_reg = '0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatch_count = 0;

   node_pair_allocator #(.NODES(NODE_COUNT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_top failed");
      $finish;
   end

   // update the shadow table; for a job, scan all pairs and queue the grant
   task automatic predict_allocation(input npa_req_type item);
      longint limit, rs, bs, ls, dr, db, slack, sc, best;
      bit have;
      int bi, bj;
      npa_rsp_type grant;
      case (item.kind)
         KIND_LOAD_NODE: begin
            node_res[item.node_index] = item.node_resource;
            node_bw[item.node_index] = item.node_bandwidth;
            node_taken[item.node_index] = item.node_busy;
         end
         KIND_LOAD_LATENCY: begin
            node_lat[item.node_index] = item.node_latency;
         end
         KIND_ALLOCATE: begin
            limit = longint'(item.job_latency) - longint'(offset_reg);
            have = 1'b0;
            best = 0;
            bi = 0;
            bj = 0;
            for (int i = 0; i < NODE_COUNT; i++) begin
               if (node_taken[i] || longint'(node_lat[i]) > limit) continue;
               for (int j = i; j < NODE_COUNT; j++) begin
                  if (node_taken[j] || longint'(node_lat[j]) > limit) continue;
                  rs = longint'(node_res[i]);
                  bs = longint'(node_bw[i]);
                  ls = longint'(node_lat[i]);
                  if (j != i) begin
                     rs += longint'(node_res[j]);
                     bs += longint'(node_bw[j]);
                     ls += longint'(node_lat[j]);
                  end
                  slack = limit - ls;
                  dr = rs - longint'(item.job_resource);
                  db = bs - longint'(item.job_bandwidth);
                  if (slack < 0 || dr < 0 || db < 0) continue;
                  sc = dr * dr + db * db - slack;
                  // strict compare keeps the lowest (i, j) on a tie
                  if (!have || sc < best) begin
                     have = 1'b1;
                     best = sc;
                     bi = i;
                     bj = j;
                  end
               end
            end
            grant = '0;
            if (have) begin
               node_taken[bi] = 1'b1;
               node_taken[bj] = 1'b1;
               grant.found = 1'b1;
               grant.score = best[31:0];
               grant.first_node = bi[5:0];
               grant.second_node = bj[5:0];
               grant.single_node = (bi == bj);
            end
            expected_grants = {expected_grants, grant};
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_allocation(req_data);
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= request_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started by the stimulus process
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : grant_check
      npa_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("grant with nothing expected: found %0b first %0d second %0d",
                      rsp_data.found, rsp_data.first_node, rsp_data.second_node);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_data.found);
                  mismatch_count++;
               end
               if (rsp_data.score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_data.score);
                  mismatch_count++;
               end
               if (rsp_data.first_node !== want.first_node) begin
                  $error("first_node: expected %0d, got %0d",
                         want.first_node, rsp_data.first_node);
                  mismatch_count++;
               end
               if (rsp_data.second_node !== want.second_node) begin
                  $error("second_node: expected %0d, got %0d",
                         want.second_node, rsp_data.second_node);
                  mismatch_count++;
               end
               if (rsp_data.single_node !== want.single_node) begin
                  $error("single_node: expected %0b, got %0b",
                         want.single_node, rsp_data.single_node);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // offset register writer
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) offset_reg = csr_data;
         if (!csr_valid || csr_ready) begin
            if (offset_writes.size() != 0) begin
               csr_valid <= 1'b1;
               csr_data <= offset_writes.pop_front();
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // junk in every field, so that ignored fields still toggle
   function automatic npa_req_type random_fill();
      npa_req_type item;
      item.kind = 2'($urandom_range(0, 3));
      item.node_index = 6'($urandom_range(0, 63));
      item.node_resource = 14'($urandom_range(0, 16383));
      item.node_bandwidth = 14'($urandom_range(0, 16383));
      item.node_busy = 1'($urandom_range(0, 1));
      item.node_latency = 16'($urandom_range(0, 65535));
      item.job_resource = 14'($urandom_range(0, 16383));
      item.job_bandwidth = 14'($urandom_range(0, 16383));
      item.job_latency = 16'($urandom_range(0, 65535));
      return item;
   endfunction

   // mostly small values, some full range, some at either extreme
   function automatic int pick_level(input int top, input int small_top);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return top;
         2, 3, 4, 5, 6: return $urandom_range(0, small_top);
         default: return $urandom_range(0, top);
      endcase
   endfunction

   task automatic queue_node_entry(input int idx, input int res, input int bw, input bit busy);
      npa_req_type item;
      item = random_fill();
      item.kind = KIND_LOAD_NODE;
      item.node_index = 6'(idx);
      item.node_resource = 14'(res);
      item.node_bandwidth = 14'(bw);
      item.node_busy = busy;
      request_backlog = {request_backlog, item};
   endtask

   task automatic queue_node_latency(input int idx, input int lat);
      npa_req_type item;
      item = random_fill();
      item.kind = KIND_LOAD_LATENCY;
      item.node_index = 6'(idx);
      item.node_latency = 16'(lat);
      request_backlog = {request_backlog, item};
   endtask

   task automatic queue_job(input int res, input int bw, input int lat);
      npa_req_type item;
      item = random_fill();
      item.kind = KIND_ALLOCATE;
      item.job_resource = 14'(res);
      item.job_bandwidth = 14'(bw);
      item.job_latency = 16'(lat);
      request_backlog = {request_backlog, item};
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_grants.size() != 0);
   endtask

   // offset changes only with the block idle; loads may still be settling
   task automatic apply_offset(input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      offset_writes = {offset_writes, value};
      do @(negedge clock);
      while (offset_writes.size() != 0 || csr_valid);
   endtask

   task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                            input logic [15:0] offset, input bit long_hold);
      npa_req_type item;
      int added;
      int roll;
      int lat;
      apply_offset(offset);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      if (long_hold) hold_requests++;
      added = 0;
      // two jobs up front: one result waits, the next job backs up the input
      if (long_hold) begin
         queue_job(0, 0, 65535);
         queue_job(0, 0, 65535);
         added = 2;
      end
      while (added < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            item = random_fill();
            item.kind = KIND_UNUSED;
            request_backlog = {request_backlog, item};
         end else begin
            if (roll < 42) begin
               queue_node_entry($urandom_range(0, 63), pick_level(16383, 300),
                                pick_level(16383, 300), $urandom_range(0, 9) == 0);
            end else if (roll < 60) begin
               queue_node_latency($urandom_range(0, 63), pick_level(65535, 3000));
            end else begin
               case ($urandom_range(0, 9))
                  0: lat = 0;
                  1: lat = 65535;
                  default: lat = $urandom_range(2000, 65535);
               endcase
               queue_job(pick_level(16383, 2000), pick_level(16383, 2000), lat);
            end
            added++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table, every node parked busy
      apply_offset(16'd0);
      for (int n = 0; n < NODE_COUNT; n++) begin
         queue_node_entry(n, $urandom_range(0, 16383), $urandom_range(0, 16383), 1'b1);
         queue_node_latency(n, $urandom_range(0, 65535));
      end

      // every node busy: not found
      queue_job(0, 0, 65535);
      // exact fit on one node with full slack: lowest possible score
      queue_node_entry(5, 100, 200, 1'b0);
      queue_node_latency(5, 0);
      queue_job(100, 200, 65535);
      // extreme capacities and latencies at both ends of the table
      queue_node_entry(0, 16383, 16383, 1'b0);
      queue_node_latency(0, 0);
      queue_node_entry(63, 16383, 16383, 1'b0);
      queue_node_latency(63, 65535);
      queue_job(0, 0, 65535);
      queue_job(16383, 16383, 65535);
      // only a true pair meets the demand
      queue_node_entry(10, 8000, 8000, 1'b0);
      queue_node_latency(10, 100);
      queue_node_entry(20, 8000, 8000, 1'b0);
      queue_node_latency(20, 200);
      queue_job(16000, 16000, 1000);
      // two identical nodes: tie goes to the lower index, then the other one
      queue_node_entry(30, 50, 50, 1'b0);
      queue_node_latency(30, 10);
      queue_node_entry(31, 50, 50, 1'b0);
      queue_node_latency(31, 10);
      queue_job(50, 50, 100);
      queue_job(50, 50, 100);

      // offset above the job latency leaves a negative limit
      apply_offset(16'd1000);
      queue_node_entry(40, 0, 0, 1'b0);
      queue_node_latency(40, 0);
      queue_job(0, 0, 999);
      queue_job(0, 0, 1000);
      // unused kind: no effect, no grant
      request_backlog = {request_backlog, random_fill()};
      request_backlog[$].kind = KIND_UNUSED;

      // random phases; the drain before each offset write pauses the sender
      run_phase(22, 0, 0, 16'd0, 1'b0);
      run_phase(20, 73, 0, 16'($urandom_range(1, 3000)), 1'b0);
      run_phase(20, 0, 73, 16'hFFFF, 1'b0);
      run_phase(20, 28, 28, 16'($urandom_range(0, 20000)), 1'b0);
      run_phase(22, 0, 0, 16'($urandom_range(0, 1000)), 1'b1);
      run_phase(20, 28, 28, 16'd0, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
